/* rtl/crws_pkg.sv */
// Package with the constants, types and codes of the cheapest run window search.
package crws_pkg;

  localparam int HORIZON_HOURS   = 48;
  localparam int MINUTES_PER_SLOT = 60;
  localparam int PRICE_BITS      = 24;

  localparam int HORIZON_MINUTES = HORIZON_HOURS * MINUTES_PER_SLOT;

  localparam int SLOT_FIELD_W = 6;
  localparam int VALUE_W      = 24;
  localparam int MIN_W        = 12;
  localparam int SUM_W        = 36;

  localparam int SLOT_W = $clog2(HORIZON_HOURS + 1);
  localparam int ADDR_W = (HORIZON_HOURS > 1) ? $clog2(HORIZON_HOURS) : 1;
  localparam int OFS_W  = (MINUTES_PER_SLOT > 1) ? $clog2(MINUTES_PER_SLOT) : 1;

  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + MINUTES_PER_SLOT - 1) / MINUTES_PER_SLOT;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = MIN_W + RECIP_W;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic STATUS_FOUND  = 1'b0;
  localparam logic STATUS_NO_FIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_OFS,
    ST_FILL_RD,
    ST_FILL_ADD,
    ST_INIT,
    ST_CHECK,
    ST_SUB_RD,
    ST_SUB,
    ST_ADD_RD,
    ST_ADD,
    ST_RESULT
  } state_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB,
    ACC_INIT,
    ACC_CMP
  } acc_op_e;

  typedef struct packed {
    acc_op_e            op;
    logic [MIN_W-1:0]   cursor;
  } acc_ctrl_t;

  typedef struct packed {
    logic load;
    logic status;
  } res_ctrl_t;

endpackage

/* rtl/crws_price_mem.sv */
// Hourly price memory with one write port and one registered read port.
module crws_price_mem (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [crws_pkg::ADDR_W-1:0]              wr_addr_i,
  input  logic signed [crws_pkg::PRICE_BITS-1:0]   wr_data_i,
  input  logic [crws_pkg::ADDR_W-1:0]              rd_addr_i,
  output logic signed [crws_pkg::PRICE_BITS-1:0]   rd_data_o
);

  logic signed [crws_pkg::PRICE_BITS-1:0] mem_q [crws_pkg::HORIZON_HOURS];
  logic signed [crws_pkg::PRICE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/crws_acc.sv */
// Shared add and subtract unit with the running window sum and the lowest sum tracker.
module crws_acc (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  crws_pkg::acc_ctrl_t                     ctrl_i,
  input  logic signed [crws_pkg::PRICE_BITS-1:0]  price_i,
  output logic signed [crws_pkg::SUM_W-1:0]       lowest_sum_o,
  output logic [crws_pkg::MIN_W-1:0]              lowest_start_o
);

  logic signed [crws_pkg::SUM_W-1:0] window_sum_q, window_sum_d;
  logic signed [crws_pkg::SUM_W-1:0] lowest_sum_q, lowest_sum_d;
  logic [crws_pkg::MIN_W-1:0]        lowest_start_q, lowest_start_d;
  logic signed [crws_pkg::SUM_W-1:0] operand;
  logic signed [crws_pkg::SUM_W-1:0] addend;
  logic signed [crws_pkg::SUM_W-1:0] alu_sum;
  logic                              sub;

  assign sub     = (ctrl_i.op == crws_pkg::ACC_SUB);
  assign operand = crws_pkg::SUM_W'(price_i);
  assign addend  = sub ? ~operand : operand;
  assign alu_sum = window_sum_q + addend + crws_pkg::SUM_W'(sub);

  always_comb begin
    window_sum_d   = window_sum_q;
    lowest_sum_d   = lowest_sum_q;
    lowest_start_d = lowest_start_q;
    case (ctrl_i.op)
      crws_pkg::ACC_CLEAR: begin
        window_sum_d = '0;
      end
      crws_pkg::ACC_ADD, crws_pkg::ACC_SUB: begin
        window_sum_d = alu_sum;
      end
      crws_pkg::ACC_INIT: begin
        lowest_sum_d   = window_sum_q;
        lowest_start_d = ctrl_i.cursor;
      end
      crws_pkg::ACC_CMP: begin
        if (window_sum_q < lowest_sum_q) begin
          lowest_sum_d   = window_sum_q;
          lowest_start_d = ctrl_i.cursor;
        end
      end
      default: begin
        window_sum_d = window_sum_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_sum_q   <= '0;
      lowest_sum_q   <= '0;
      lowest_start_q <= '0;
    end else begin
      window_sum_q   <= window_sum_d;
      lowest_sum_q   <= lowest_sum_d;
      lowest_start_q <= lowest_start_d;
    end
  end

  assign lowest_sum_o   = lowest_sum_q;
  assign lowest_start_o = lowest_start_q;

  a_init_copies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == crws_pkg::ACC_INIT |=> lowest_sum_q == window_sum_q)
    else $error("Lowest sum does not match the window sum after init.");

  a_cmp_never_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == crws_pkg::ACC_CMP |=> lowest_sum_q <= $past(lowest_sum_q))
    else $error("Compare raised the lowest sum.");

  a_slide_keeps_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == crws_pkg::ACC_ADD || ctrl_i.op == crws_pkg::ACC_SUB)
    |=> $stable(lowest_sum_q) && $stable(lowest_start_q))
    else $error("Best window changed during an add or subtract step.");

endmodule

/* rtl/crws_seq.sv */
// Sequencer that walks the fill and slide steps of one search.
module crws_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  func_i,
  input  logic [crws_pkg::MIN_W-1:0]            first_minute_i,
  input  logic [crws_pkg::MIN_W-1:0]            run_minutes_i,
  input  logic                                  out_busy_i,
  output logic                                  in_stall_o,
  output logic [crws_pkg::ADDR_W-1:0]           rd_addr_o,
  output crws_pkg::acc_ctrl_t                   acc_ctrl_o,
  output crws_pkg::res_ctrl_t                   res_o
);

  crws_pkg::state_e state_q, state_d;

  logic [crws_pkg::MIN_W-1:0]  first_q, first_d;
  logic [crws_pkg::MIN_W-1:0]  remaining_q, remaining_d;
  logic [crws_pkg::MIN_W-1:0]  cursor_q, cursor_d;
  logic [crws_pkg::SLOT_W-1:0] enter_slot_q, enter_slot_d;
  logic [crws_pkg::OFS_W-1:0]  enter_ofs_q, enter_ofs_d;
  logic [crws_pkg::SLOT_W-1:0] leave_slot_q, leave_slot_d;
  logic [crws_pkg::OFS_W-1:0]  leave_ofs_q, leave_ofs_d;
  logic                        no_fit_q, no_fit_d;

  logic                        accept;
  logic [crws_pkg::MIN_W:0]    end_minute;
  logic                        no_fit;
  logic [crws_pkg::PROD_W-1:0] quot_prod;
  logic [crws_pkg::MIN_W-1:0]  slot_base;
  logic [crws_pkg::MIN_W-1:0]  ofs_full;
  logic                        enter_wrap;
  logic                        leave_wrap;
  logic                        enter_in_range;

  assign accept     = in_valid_i && (state_q == crws_pkg::ST_IDLE);
  assign end_minute = {1'b0, first_minute_i} + {1'b0, run_minutes_i};
  assign no_fit     = (run_minutes_i == '0) || (32'(end_minute) > crws_pkg::HORIZON_MINUTES);
  assign quot_prod  = crws_pkg::PROD_W'(first_q) * crws_pkg::PROD_W'(crws_pkg::RECIP);
  assign slot_base  = crws_pkg::MIN_W'(enter_slot_q) *
                      crws_pkg::MIN_W'(crws_pkg::MINUTES_PER_SLOT);
  assign ofs_full   = first_q - slot_base;
  assign enter_wrap = (32'(enter_ofs_q) == crws_pkg::MINUTES_PER_SLOT - 1);
  assign leave_wrap = (32'(leave_ofs_q) == crws_pkg::MINUTES_PER_SLOT - 1);
  assign enter_in_range = (32'(enter_slot_q) < crws_pkg::HORIZON_HOURS);

  always_comb begin
    state_d      = state_q;
    first_d      = first_q;
    remaining_d  = remaining_q;
    cursor_d     = cursor_q;
    enter_slot_d = enter_slot_q;
    enter_ofs_d  = enter_ofs_q;
    leave_slot_d = leave_slot_q;
    leave_ofs_d  = leave_ofs_q;
    no_fit_d     = no_fit_q;
    acc_ctrl_o.op     = crws_pkg::ACC_HOLD;
    acc_ctrl_o.cursor = cursor_q;
    res_o.load   = 1'b0;
    res_o.status = no_fit_q;
    rd_addr_o    = crws_pkg::ADDR_W'(enter_slot_q);
    in_stall_o   = (state_q != crws_pkg::ST_IDLE);

    case (state_q)
      crws_pkg::ST_IDLE: begin
        if (accept && func_i == crws_pkg::FUNC_SEARCH) begin
          first_d     = first_minute_i;
          remaining_d = run_minutes_i;
          cursor_d    = first_minute_i;
          no_fit_d    = no_fit;
          if (no_fit) begin
            state_d = crws_pkg::ST_RESULT;
          end else begin
            acc_ctrl_o.op = crws_pkg::ACC_CLEAR;
            state_d       = crws_pkg::ST_DIV;
          end
        end
      end
      crws_pkg::ST_DIV: begin
        enter_slot_d = crws_pkg::SLOT_W'(quot_prod >> crws_pkg::RECIP_SHIFT);
        state_d      = crws_pkg::ST_OFS;
      end
      crws_pkg::ST_OFS: begin
        enter_ofs_d  = crws_pkg::OFS_W'(ofs_full);
        leave_ofs_d  = crws_pkg::OFS_W'(ofs_full);
        leave_slot_d = enter_slot_q;
        state_d      = crws_pkg::ST_FILL_RD;
      end
      crws_pkg::ST_FILL_RD: begin
        state_d = crws_pkg::ST_FILL_ADD;
      end
      crws_pkg::ST_FILL_ADD: begin
        acc_ctrl_o.op = crws_pkg::ACC_ADD;
        if (enter_wrap) begin
          enter_ofs_d  = '0;
          enter_slot_d = enter_slot_q + 1'b1;
        end else begin
          enter_ofs_d = enter_ofs_q + 1'b1;
        end
        remaining_d = remaining_q - 1'b1;
        if (remaining_q == crws_pkg::MIN_W'(1)) begin
          state_d = crws_pkg::ST_INIT;
        end else begin
          state_d = crws_pkg::ST_FILL_RD;
        end
      end
      crws_pkg::ST_INIT: begin
        acc_ctrl_o.op = crws_pkg::ACC_INIT;
        state_d       = crws_pkg::ST_CHECK;
      end
      crws_pkg::ST_CHECK: begin
        acc_ctrl_o.op = crws_pkg::ACC_CMP;
        if (enter_in_range) begin
          state_d = crws_pkg::ST_SUB_RD;
        end else begin
          state_d = crws_pkg::ST_RESULT;
        end
      end
      crws_pkg::ST_SUB_RD: begin
        rd_addr_o = crws_pkg::ADDR_W'(leave_slot_q);
        state_d   = crws_pkg::ST_SUB;
      end
      crws_pkg::ST_SUB: begin
        acc_ctrl_o.op = crws_pkg::ACC_SUB;
        if (leave_wrap) begin
          leave_ofs_d  = '0;
          leave_slot_d = leave_slot_q + 1'b1;
        end else begin
          leave_ofs_d = leave_ofs_q + 1'b1;
        end
        state_d = crws_pkg::ST_ADD_RD;
      end
      crws_pkg::ST_ADD_RD: begin
        state_d = crws_pkg::ST_ADD;
      end
      crws_pkg::ST_ADD: begin
        acc_ctrl_o.op = crws_pkg::ACC_ADD;
        if (enter_wrap) begin
          enter_ofs_d  = '0;
          enter_slot_d = enter_slot_q + 1'b1;
        end else begin
          enter_ofs_d = enter_ofs_q + 1'b1;
        end
        cursor_d = cursor_q + 1'b1;
        state_d  = crws_pkg::ST_CHECK;
      end
      crws_pkg::ST_RESULT: begin
        if (!out_busy_i) begin
          res_o.load = 1'b1;
          state_d    = crws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = crws_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crws_pkg::ST_IDLE;
      remaining_q <= '0;
      cursor_q    <= '0;
      no_fit_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      remaining_q <= remaining_d;
      cursor_q    <= cursor_d;
      no_fit_q    <= no_fit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q      <= first_d;
    enter_slot_q <= enter_slot_d;
    enter_ofs_q  <= enter_ofs_d;
    leave_slot_q <= leave_slot_d;
    leave_ofs_q  <= leave_ofs_d;
  end

  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crws_pkg::ST_FILL_ADD |-> remaining_q != '0)
    else $error("Fill step taken with no minutes left.");

  a_leave_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crws_pkg::ST_SUB_RD |-> 32'(leave_slot_q) < crws_pkg::HORIZON_HOURS)
    else $error("Leaving minute lies beyond the horizon.");

  a_enter_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crws_pkg::ST_FILL_RD || state_q == crws_pkg::ST_ADD_RD) |-> enter_in_range)
    else $error("Entering minute lies beyond the horizon.");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load |=> state_q == crws_pkg::ST_IDLE)
    else $error("Sequencer did not return to idle after a result.");

endmodule

/* rtl/cheapest_run_window_search.sv */
// Top level of the cheapest run window search over a table of hourly prices.
//
//   Channel | Valid       | Stall       | Payload
//   in      | in_valid_i  | in_stall_o  | func_i, price_slot_i, price_value_i,
//           |             |             | first_minute_i, run_minutes_i
//   out     | out_valid_o | out_stall_i | best_start_o, best_sum_o, status_o
//
// A load transaction gives no result.
// A search is paced by the single adder and the one read port of the price memory,
// and its result is handed over from a separate result state.
// A search that does not fit goes straight to the result state.
// The output register holds a result while out_stall_i is high; a new transaction
// is taken meanwhile and waits only at its own result.
// Price entries are undefined after reset until a load writes them.
module cheapest_run_window_search (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    func_i,
  input  logic [crws_pkg::SLOT_FIELD_W-1:0]       price_slot_i,
  input  logic signed [crws_pkg::VALUE_W-1:0]     price_value_i,
  input  logic [crws_pkg::MIN_W-1:0]              first_minute_i,
  input  logic [crws_pkg::MIN_W-1:0]              run_minutes_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [crws_pkg::MIN_W-1:0]              best_start_o,
  output logic signed [crws_pkg::SUM_W-1:0]       best_sum_o,
  output logic                                    status_o
);

  crws_pkg::acc_ctrl_t acc_ctrl;
  crws_pkg::res_ctrl_t res;

  logic [crws_pkg::ADDR_W-1:0]             rd_addr;
  logic signed [crws_pkg::PRICE_BITS-1:0]  rd_price;
  logic signed [crws_pkg::SUM_W-1:0]       lowest_sum;
  logic [crws_pkg::MIN_W-1:0]              lowest_start;
  logic                                    wr_en;
  logic                                    out_busy;

  logic                              out_valid_q, out_valid_d;
  logic [crws_pkg::MIN_W-1:0]        out_start_q, out_start_d;
  logic signed [crws_pkg::SUM_W-1:0] out_sum_q, out_sum_d;
  logic                              out_status_q, out_status_d;

  assign wr_en = in_valid_i && !in_stall_o && (func_i == crws_pkg::FUNC_LOAD) &&
                 (32'(price_slot_i) < crws_pkg::HORIZON_HOURS);
  assign out_busy = out_valid_q && out_stall_i;

  crws_price_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (crws_pkg::ADDR_W'(price_slot_i)),
    .wr_data_i (crws_pkg::PRICE_BITS'(price_value_i)),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_price)
  );

  crws_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .func_i         (func_i),
    .first_minute_i (first_minute_i),
    .run_minutes_i  (run_minutes_i),
    .out_busy_i     (out_busy),
    .in_stall_o     (in_stall_o),
    .rd_addr_o      (rd_addr),
    .acc_ctrl_o     (acc_ctrl),
    .res_o          (res)
  );

  crws_acc u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (acc_ctrl),
    .price_i        (rd_price),
    .lowest_sum_o   (lowest_sum),
    .lowest_start_o (lowest_start)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_start_d  = out_start_q;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    if (res.load) begin
      out_valid_d  = 1'b1;
      out_status_d = res.status;
      if (res.status == crws_pkg::STATUS_NO_FIT) begin
        out_start_d = '0;
        out_sum_d   = '0;
      end else begin
        out_start_d = lowest_start;
        out_sum_d   = lowest_sum;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q  <= out_start_d;
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign best_start_o = out_start_q;
  assign best_sum_o   = out_sum_q;
  assign status_o     = out_status_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load |-> !out_busy)
    else $error("Result loaded over a transaction still waiting.");

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> acc_ctrl.op == crws_pkg::ACC_HOLD)
    else $error("Price written while a search is running.");

  a_no_fit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.load && res.status == crws_pkg::STATUS_NO_FIT |=> best_sum_o == '0 && best_start_o == '0)
    else $error("No-fit result carries a nonzero start or sum.");

endmodule
